// ----- sv/lfsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lfsm_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int LINE_LIMIT_DEF  = 510;
  localparam int WINDOW_DEPTH    = 8;
  localparam int PATTERN_W       = 64;
  localparam int PLEN_W          = 4;
  localparam int LEN_W           = 9;
  localparam int COUNT_W         = 32;
  localparam int CFG_IDX_W       = 8;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = CFG_IDX_W'(0),
    REG_PATTERN_LENGTH = CFG_IDX_W'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_file;
  } in_item_t;

  typedef struct packed {
    logic               line_matched;
    logic [LEN_W-1:0]   line_length;
    logic               cut_at_limit;
    logic [COUNT_W-1:0] match_count;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [PATTERN_W-1:0] wdata;
  } cfg_write_t;

endpackage
`default_nettype wire

// ----- sv/lfsm_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface lfsm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/line_fixed_string_matcher_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A byte beat that ends a line shows its result in the result register from the cycle after its acceptance.
// Throughput: one byte per cycle; the window compare and line counters update in the cycle
// of acceptance, and the only stall comes from a result held by a slow consumer.
// Reset (rst_ni, async, active low) clears the window, line length, hit flag, match count,
// the pattern registers and the result valid. No clearing pass is needed.
module line_fixed_string_matcher_top
  import lfsm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int LINE_LIMIT  = LINE_LIMIT_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  lfsm_chan_if.sink       cfg_i,
  lfsm_chan_if.sink       in_i,
  lfsm_chan_if.source     res_o
);

  localparam int CNT_W     = $clog2(LINE_LIMIT + 1);
  localparam int WIN_IDX_W = $clog2(WINDOW_DEPTH);

  logic [PATTERN_W-1:0] pat_q;
  logic [PLEN_W-1:0]    plen_q;

  logic [7:0]           win_q [WINDOW_DEPTH];
  logic [CNT_W-1:0]     cnt_q;
  logic                 hit_q;
  logic [COUNT_W-1:0]   mc_q;
  logic                 res_valid_q;
  out_item_t            res_q;

  logic                 in_ready;
  logic                 in_acc;
  in_item_t             item;
  logic [7:0]           win_n [WINDOW_DEPTH];
  logic [CNT_W-1:0]     cnt_n;
  logic                 hit_base;
  logic                 hit_n;
  logic [COUNT_W-1:0]   mc_base;
  logic [COUNT_W-1:0]   mc_n;
  logic [PLEN_W-1:0]    plen_c;
  logic [WIN_IDX_W-1:0] widx;
  logic                 win_match;
  logic                 at_nl;
  logic                 at_lim;
  logic                 line_end;

  // Config: always ready, unknown indexes dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.idx)
        REG_PATTERN_BYTES:  pat_q  <= cfg_i.data.wdata;
        REG_PATTERN_LENGTH: plen_q <= cfg_i.data.wdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready    = !res_valid_q || res_o.ready;
  assign in_i.ready  = in_ready;
  assign in_acc      = in_i.valid && in_ready;
  assign item        = in_i.data;

  assign plen_c = (plen_q > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : plen_q;

  always_comb begin
    hit_base = item.first_of_file ? 1'b0 : hit_q;
    mc_base  = item.first_of_file ? '0 : mc_q;
    cnt_n    = (item.first_of_file ? '0 : cnt_q) + CNT_W'(1);
    win_n[0] = item.data_byte;
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      win_n[i] = item.first_of_file ? 8'h00 : win_q[i-1];
    end

    // win_n[0] is the newest byte, so pattern byte k sits at plen-1-k
    win_match = ({{(PLEN_W){1'b0}}, cnt_n} >= {{(CNT_W){1'b0}}, plen_c});
    widx = '0;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      widx = WIN_IDX_W'(plen_c - PLEN_W'(k) - PLEN_W'(1));
      if (PLEN_W'(k) < plen_c && win_n[widx] != pat_q[8*k +: 8]) begin
        win_match = 1'b0;
      end
    end

    hit_n    = hit_base || win_match;
    at_nl    = (item.data_byte == NEWLINE_BYTE);
    at_lim   = (cnt_n >= CNT_W'(LINE_LIMIT));
    line_end = at_nl || at_lim;
    mc_n     = (hit_n && (mc_base != '1)) ? mc_base + COUNT_W'(1) : mc_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= 8'h00;
      end
      cnt_q <= '0;
      hit_q <= 1'b0;
      mc_q  <= '0;
    end else if (in_acc) begin
      if (line_end) begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
          win_q[i] <= 8'h00;
        end
        cnt_q <= '0;
        hit_q <= 1'b0;
        mc_q  <= mc_n;
      end else begin
        win_q <= win_n;
        cnt_q <= cnt_n;
        hit_q <= hit_n;
        mc_q  <= mc_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_acc && line_end) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && line_end) begin
      res_q.line_matched <= hit_n;
      res_q.line_length  <= LEN_W'(cnt_n);
      res_q.cut_at_limit <= !at_nl;
      res_q.match_count  <= mc_n;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // Line length never rests at or beyond the limit
  a_cnt_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(LINE_LIMIT))
    else $error("line length register reached the limit");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && line_end |=> res_valid_q)
    else $error("line end beat produced no result");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !item.first_of_file |=> mc_q >= $past(mc_q))
    else $error("match count went down without a new file");

  a_empty_pattern_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && plen_c == '0 && !line_end |=> hit_q)
    else $error("empty pattern did not mark the line");

endmodule
`default_nettype wire

// ----- test/line_fixed_string_matcher_top_tb.sv -----
`timescale 1ns / 1ps
module line_fixed_string_matcher_top_tb;
  import lfsm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam int BLOCK_BYTES = 16;

  // Tracks the line state of the matcher and queues the verdict due at each line end.
  class line_verdict_book;
    logic [PATTERN_W-1:0] pat;
    logic [PLEN_W-1:0]    plen;
    logic [7:0]           win [WINDOW_DEPTH];
    logic [LEN_W-1:0]     len;
    bit                   hit;
    logic [COUNT_W-1:0]   count;
    out_item_t            verdicts_due [$];
    int                   fail_count;
    int                   reported;

    function void power_up();
      pat = '0;
      plen = '0;
      count = '0;
      fail_count = 0;
      reported = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (win[i]) win[i] = '0;
      len = '0;
      hit = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PATTERN_W-1:0] v);
      case (idx)
        REG_PATTERN_BYTES: pat = v;
        REG_PATTERN_LENGTH: plen = v[PLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff_len();
      return (plen > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(plen);
    endfunction

    function void note_byte(in_item_t it);
      int eff;
      bit fits;
      out_item_t v;
      if (it.first_of_file) begin
        clear_line();
        count = '0;
      end
      eff = eff_len();
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = it.data_byte;
      len++;
      // window entry 0 is the newest byte, so the pattern's last byte lines up with it
      fits = (len >= eff);
      for (int k = 0; k < eff; k++)
        if (win[eff-1-k] != pat[8*k +: 8]) fits = 1'b0;
      if (fits) hit = 1'b1;
      if (it.data_byte != NEWLINE_BYTE && len < LINE_LIMIT_DEF) return;
      if (hit && count != '1) count++;
      v.line_matched = hit;
      v.line_length  = len;
      v.cut_at_limit = (it.data_byte != NEWLINE_BYTE);
      v.match_count  = count;
      verdicts_due.push_back(v);
      clear_line();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (verdicts_due.size() == 0) begin
        fail_count++;
        if (reported < 10) begin
          reported++;
          $display("%0t: unexpected line result matched=%0b len=%0d cut=%0b count=%0d",
                   $realtime, got.line_matched, got.line_length, got.cut_at_limit,
                   got.match_count);
        end
        return;
      end
      want = verdicts_due.pop_front();
      if (got.line_matched != want.line_matched || got.line_length != want.line_length ||
          got.cut_at_limit != want.cut_at_limit || got.match_count != want.match_count) begin
        fail_count++;
        if (reported < 10) begin
          reported++;
          $display("%0t: line result mismatch: exp matched=%0b len=%0d cut=%0b count=%0d",
                   $realtime, want.line_matched, want.line_length, want.cut_at_limit,
                   want.match_count);
          $display("%0t:                        got matched=%0b len=%0d cut=%0b count=%0d",
                   $realtime, got.line_matched, got.line_length, got.cut_at_limit,
                   got.match_count);
        end
      end
    endfunction

    function void close_out();
      if (verdicts_due.size() != 0) begin
        fail_count++;
        $display("%0d line results never arrived", verdicts_due.size());
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lfsm_chan_if #(.payload_t(cfg_write_t)) cfg_if ();
  lfsm_chan_if #(.payload_t(in_item_t))   in_if ();
  lfsm_chan_if #(.payload_t(out_item_t))  res_if ();

  line_fixed_string_matcher_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  line_verdict_book book;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_req;
  int bytes_sent;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: ready changes on the falling edge, long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        res_if.ready <= 1'b0;
        hold_req--;
      end else begin
        res_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) book.check_result(res_if.data);
    end
  end

  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (res_if.valid && res_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit fof);
    in_item_t it;
    it.data_byte = b;
    it.first_of_file = fof;
    @(negedge clk_i);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    book.note_byte(it);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit fof);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fof && i == 0);
  endtask

  // mostly lines built from pattern pieces, with random bytes mixed in
  task automatic send_line();
    int body;
    int eff;
    int r;
    bit fof;
    eff = book.eff_len();
    body = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 0) : $urandom_range(12, 0);
    fof = ($urandom_range(24, 0) == 0);
    for (int i = 0; i < body; i++) begin
      r = $urandom_range(9, 0);
      if (r < 2 && eff > 0) begin
        for (int k = 0; k < eff; k++) begin
          send_byte(book.pat[8*k +: 8], fof);
          fof = 1'b0;
        end
      end else if (r < 6 && eff > 0) begin
        send_byte(book.pat[8*$urandom_range(eff - 1, 0) +: 8], fof);
        fof = 1'b0;
      end else begin
        send_byte(8'($urandom_range(255, 0)), fof);
        fof = 1'b0;
      end
    end
    // an unterminated tail just runs into the next line
    if ($urandom_range(9, 0) != 0) send_byte(NEWLINE_BYTE, fof);
  endtask

  // full-length line: either cut at the limit or closed by a newline on the last byte
  task automatic send_long_line(input bit cut);
    logic [7:0] b;
    // close any open tail so the long line starts fresh
    send_byte(NEWLINE_BYTE, 1'b0);
    for (int i = 0; i < LINE_LIMIT_DEF - 1; i++) begin
      do b = 8'($urandom_range(255, 0)); while (b == NEWLINE_BYTE);
      send_byte(b, 1'b0);
    end
    do b = 8'($urandom_range(255, 0)); while (b == NEWLINE_BYTE);
    send_byte(cut ? b : NEWLINE_BYTE, 1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (book.verdicts_due.size() != 0) @(posedge clk_i);
    // a byte that closes no line may still be in flight
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PATTERN_W-1:0] v);
    cfg_write_t w;
    w.idx = idx;
    w.wdata = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    book.write_reg(idx, v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [PATTERN_W-1:0] pat;
    logic [PATTERN_W-1:0] lenval;
    int target;
    book = new();
    book.power_up();
    src_idle_pct = 22;
    sink_idle_pct = 55;
    hold_req = 0;
    bytes_sent = 0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset pattern is empty: every line matches; start of file clears the count
    send_text("x\n", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(NEWLINE_BYTE, 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);      // "abc"
    write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF3);     // upper bits ignored
    send_text("ab\n", 1'b0);       // line too short for the pattern
    send_text("abc\n", 1'b0);
    send_text("xabcx\n", 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_BYTES, 64'h3837_3635_3433_3231);      // "12345678"
    write_reg(REG_PATTERN_LENGTH, 64'h0000_0000_0000_000F);     // clamps to 8
    send_text("12345678\n", 1'b0);
    wait_idle();
    write_reg(REG_UNMAPPED_LO, '1);
    write_reg(REG_UNMAPPED_HI, '0);

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 22 : (phase == 1) ? 55 : 0;
      sink_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 22 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        wait_idle();
        pat = {$urandom, $urandom};
        if (blk == 1 && phase == 0) pat = '0;
        if (blk == 1 && phase == 1) pat = '1;
        lenval = {$urandom, $urandom};
        lenval[PLEN_W-1:0] = (blk == 0) ? 4'd0 : (blk == 1) ? 4'd8 : 4'($urandom_range(15, 1));
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH, lenval);
        if (phase == 2 && blk == 0) hold_req = 250;
        target = bytes_sent + BLOCK_BYTES;
        while (bytes_sent < target) send_line();
        if (blk == 1 && phase < 2) send_long_line(phase == 0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    book.close_out();
    if (book.fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lfsm_pkg.sv
sv/lfsm_chan_if.sv
sv/line_fixed_string_matcher_top.sv
test/line_fixed_string_matcher_top_tb.sv
